/* hdl/wcs_pkg.sv */
// Shared types and constants of the weighted common substring block.
`default_nettype none
package wcs_pkg;

   // Fixed field widths.
   localparam int KIND_W   = 2;
   localparam int SYM_W    = 8;
   localparam int WEIGHT_W = 16;
   localparam int SCORE_W  = 24;
   localparam int POS_W    = 7;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 16;

   // Input kinds.
   localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SECOND = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY   = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [WEIGHT_W-1:0] PENALTY_RESET = 16'd2560;

   // Commands passed from the front end to the back end.
   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_FIRST  = 2'd1,
      CMD_SECOND = 2'd2
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic                run;
      logic [SYM_W-1:0]    symbol;
      logic [WEIGHT_W-1:0] weight;
   } cmd_type;

   // Configuration write bundle.
   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage
`default_nettype wire

/* hdl/wcs_req_if.sv */
// Input channel interface: one character or weight word per handshake.
`default_nettype none
interface wcs_req_if import wcs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SYM_W-1:0]    symbol;
   logic [WEIGHT_W-1:0] weight;
   logic                end_of_input;

   modport source (output valid, kind, symbol, weight, end_of_input, input ready);
   modport sink   (input valid, kind, symbol, weight, end_of_input, output ready);
endinterface
`default_nettype wire

/* hdl/wcs_rsp_if.sv */
// Result channel interface: one substring character per handshake.
`default_nettype none
interface wcs_rsp_if import wcs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] best_score;
   logic [SYM_W-1:0]   out_symbol;
   logic               is_empty;
   logic [POS_W-1:0]   end_in_first;
   logic [POS_W-1:0]   end_in_second;
   logic               overflowed;
   logic               last_of_run;

   modport source (output valid, best_score, out_symbol, is_empty, end_in_first,
                   end_in_second, overflowed, last_of_run, input ready);
   modport sink   (input valid, best_score, out_symbol, is_empty, end_in_first,
                   end_in_second, overflowed, last_of_run, output ready);
endinterface
`default_nettype wire

/* hdl/wcs_fifo.sv */
// Two-entry command queue between the front end and the back end.
`default_nettype none
module wcs_fifo import wcs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         pop_valid,
   output cmd_type      pop_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* hdl/wcs_front.sv */
// Front end: accepts input words and turns them into back-end commands.
`default_nettype none
module wcs_front import wcs_pkg::*; (
   wcs_req_if.sink req_ch,
   input  wire logic queue_full,
   output logic      push,
   output cmd_type   push_cmd
);

   assign req_ch.ready = !queue_full;

   // Classify the word; unknown kinds are consumed without a command.
   always_comb begin
      push_cmd.symbol = req_ch.symbol;
      push_cmd.weight = req_ch.weight;
      push_cmd.run    = 1'b0;
      push_cmd.op     = CMD_WEIGHT;
      push            = 1'b0;
      unique case (req_ch.kind)
         KIND_WEIGHT: begin
            push_cmd.op = CMD_WEIGHT;
            push        = req_ch.valid && !queue_full;
         end
         KIND_FIRST: begin
            push_cmd.op = CMD_FIRST;
            push        = req_ch.valid && !queue_full;
         end
         KIND_SECOND: begin
            push_cmd.op  = CMD_SECOND;
            push_cmd.run = req_ch.end_of_input;
            push         = req_ch.valid && !queue_full;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hdl/wcs_back.sv */
// Back end: string storage, diagonal score sweep, walk back and result output.
`default_nettype none
module wcs_back import wcs_pkg::*; #(
   parameter int MAX_LEN = 64,
   parameter int WEIGHT_FRAC_BITS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire csr_wr_type csr,
   input  wire logic       cmd_valid,
   input  wire cmd_type    cmd,
   output logic            cmd_pop,
   wcs_rsp_if.source       rsp_ch
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int WW = 17;
   localparam logic [WW-1:0] UNIT_W = WW'(1) << WEIGHT_FRAC_BITS;
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEN);
   localparam logic [LW-1:0] ONE = LW'(1);

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_INIT  = 13'b0000000000010,
      S_ROWA  = 13'b0000000000100,
      S_ROWB  = 13'b0000000001000,
      S_CELL  = 13'b0000000010000,
      S_TB0   = 13'b0000000100000,
      S_TBR   = 13'b0000001000000,
      S_TBW   = 13'b0000010000000,
      S_TBU   = 13'b0000100000000,
      S_EMRD  = 13'b0001000000000,
      S_EMWR  = 13'b0010000000000,
      S_EMPTY = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic                unit_ff;
   logic [WEIGHT_W-1:0] pen_ff;

   // Memories and their registered read data.
   logic [WEIGHT_W-1:0] wmem [256];
   logic [255:0]        wvalid_ff;
   logic [WEIGHT_W-1:0] wmem_q;
   logic                wval_q;
   logic [SYM_W-1:0]    first_mem [MAX_LEN];
   logic [SYM_W-1:0]    second_mem [MAX_LEN];
   logic [SCORE_W-1:0]  row_mem [MAX_LEN];
   logic [SYM_W-1:0]    first_q, second_q;
   logic [SCORE_W-1:0]  row_q;

   // Memory controls.
   logic             w_we, w_re;
   logic [SYM_W-1:0] w_wa, w_ra;
   logic             f_we, f_re, s_we, s_re, r_we, r_re;
   logic [AW-1:0]    f_wa, f_ra, s_wa, s_ra, r_wa, r_ra;
   logic [SCORE_W-1:0] r_wd;

   // Datapath registers.
   logic [LW-1:0]      len1_ff, len2_ff;
   logic               drop_ff;
   logic [LW-1:0]      i_ff, j_ff, ti_ff, tj_ff, n_ff, k_ff;
   logic [SYM_W-1:0]   a_ff;
   logic [WW-1:0]      wt_ff;
   logic [SCORE_W-1:0] diag_ff, best_ff, s_ff;
   logic [LW-1:0]      brow_ff, bcol_ff;
   logic               match_ff;

   // Output register.
   logic               rv_ff;
   logic [SCORE_W-1:0] r_score_ff;
   logic [SYM_W-1:0]   r_sym_ff;
   logic               r_empty_ff;
   logic [POS_W-1:0]   r_e1_ff, r_e2_ff;
   logic               r_over_ff, r_last_ff;
   logic               out_free, out_load;

   // Arithmetic of one cell.
   logic [WW-1:0]      cur_wt;
   logic [SCORE_W-1:0] above, cell_v, tb_next;
   logic [SCORE_W:0]   cell_sum, tb_sum;
   logic [LW-1:0]      i_m1, j_m1, ti_m1, tj_m1, em_addr;

   assign out_free = !rv_ff || rsp_ch.ready;
   assign cmd_pop  = (state_ff == S_IDLE) && cmd_valid;

   assign cur_wt = unit_ff ? UNIT_W : (wval_q ? WW'(wmem_q) : WW'(0));
   assign above  = (i_ff == ONE) ? SCORE_W'(0) : row_q;

   assign i_m1    = i_ff - ONE;
   assign j_m1    = j_ff - ONE;
   assign ti_m1   = ti_ff - ONE;
   assign tj_m1   = tj_ff - ONE;
   assign em_addr = brow_ff - n_ff + k_ff;

   // Cell score: saturating add on a match, clamped subtract otherwise.
   always_comb begin
      cell_sum = {1'b0, diag_ff} + (SCORE_W+1)'(wt_ff);
      if (a_ff == second_q) begin
         cell_v = cell_sum[SCORE_W] ? {SCORE_W{1'b1}} : cell_sum[SCORE_W-1:0];
      end else if (diag_ff >= SCORE_W'(pen_ff)) begin
         cell_v = diag_ff - SCORE_W'(pen_ff);
      end else begin
         cell_v = '0;
      end
   end

   // Walk-back step: undo the cell update.
   always_comb begin
      tb_sum = {1'b0, s_ff} + (SCORE_W+1)'(pen_ff);
      if (!match_ff) begin
         tb_next = tb_sum[SCORE_W] ? {SCORE_W{1'b1}} : tb_sum[SCORE_W-1:0];
      end else if (s_ff >= SCORE_W'(cur_wt)) begin
         tb_next = s_ff - SCORE_W'(cur_wt);
      end else begin
         tb_next = '0;
      end
   end

   // Sequencer: next state and memory controls.
   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      w_we = 1'b0; w_wa = cmd.symbol;
      w_re = 1'b0; w_ra = first_q;
      f_we = 1'b0; f_wa = len1_ff[AW-1:0];
      s_we = 1'b0; s_wa = len2_ff[AW-1:0];
      f_re = 1'b0; f_ra = '0;
      s_re = 1'b0; s_ra = '0;
      r_re = 1'b0; r_ra = '0;
      r_we = 1'b0; r_wa = j_m1[AW-1:0]; r_wd = cell_v;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.op)
                  CMD_WEIGHT: w_we = 1'b1;
                  CMD_FIRST:  f_we = (len1_ff < LEN_MAX);
                  default: begin
                     s_we = (len2_ff < LEN_MAX);
                     if (cmd.run) begin
                        state_in = S_INIT;
                     end
                  end
               endcase
            end
         end
         S_INIT: begin
            if (len1_ff == '0 || len2_ff == '0) begin
               state_in = S_TB0;
            end else begin
               f_re = 1'b1;
               state_in = S_ROWA;
            end
         end
         S_ROWA: begin
            w_re = 1'b1;
            w_ra = first_q;
            s_re = 1'b1;
            r_re = 1'b1;
            state_in = S_ROWB;
         end
         S_ROWB: begin
            state_in = S_CELL;
         end
         S_CELL: begin
            r_we = 1'b1;
            if (j_ff < len2_ff) begin
               s_re = 1'b1;
               s_ra = j_ff[AW-1:0];
               r_re = 1'b1;
               r_ra = j_ff[AW-1:0];
            end else if (i_ff < len1_ff) begin
               f_re = 1'b1;
               f_ra = i_ff[AW-1:0];
               state_in = S_ROWA;
            end else begin
               state_in = S_TB0;
            end
         end
         S_TB0: begin
            state_in = (best_ff == '0) ? S_EMPTY : S_TBR;
         end
         S_TBR: begin
            if (s_ff != '0 && ti_ff != '0 && tj_ff != '0) begin
               f_re = 1'b1;
               f_ra = ti_m1[AW-1:0];
               s_re = 1'b1;
               s_ra = tj_m1[AW-1:0];
               state_in = S_TBW;
            end else begin
               state_in = S_EMRD;
            end
         end
         S_TBW: begin
            w_re = 1'b1;
            w_ra = first_q;
            state_in = S_TBU;
         end
         S_TBU: begin
            state_in = S_TBR;
         end
         S_EMRD: begin
            f_re = 1'b1;
            f_ra = em_addr[AW-1:0];
            state_in = S_EMWR;
         end
         S_EMWR: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = (k_ff == n_ff - ONE) ? S_FIN : S_EMRD;
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Weight table with a valid bit per entry.
   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_wa] <= cmd.weight;
      end
      if (w_re) begin
         wmem_q <= wmem[w_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff <= '0;
         wval_q    <= 1'b0;
      end else begin
         if (w_we) begin
            wvalid_ff[w_wa] <= 1'b1;
         end
         if (w_re) begin
            wval_q <= wvalid_ff[w_ra];
         end
      end
   end

   // String and score row memories.
   always_ff @(posedge clock) begin
      if (f_we) begin
         first_mem[f_wa] <= cmd.symbol;
      end
      if (f_re) begin
         first_q <= first_mem[f_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         second_mem[s_wa] <= cmd.symbol;
      end
      if (s_re) begin
         second_q <= second_mem[s_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         row_mem[r_wa] <= r_wd;
      end
      if (r_re) begin
         row_q <= row_mem[r_ra];
      end
   end

   // Control state, configuration and lengths.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         unit_ff  <= 1'b1;
         pen_ff   <= PENALTY_RESET;
         len1_ff  <= '0;
         len2_ff  <= '0;
         drop_ff  <= 1'b0;
         best_ff  <= '0;
         brow_ff  <= '0;
         bcol_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.we) begin
            case (csr.index)
               CSR_UNIT_MODE: unit_ff <= csr.data[0];
               default:       pen_ff  <= csr.data[WEIGHT_W-1:0];
            endcase
         end
         if (f_we) begin
            len1_ff <= len1_ff + ONE;
         end
         if (s_we) begin
            len2_ff <= len2_ff + ONE;
         end
         if (cmd_pop && cmd.op != CMD_WEIGHT) begin
            if ((cmd.op == CMD_FIRST && !f_we) || (cmd.op == CMD_SECOND && !s_we)) begin
               drop_ff <= 1'b1;
            end
         end
         if (state_ff == S_INIT) begin
            best_ff <= '0;
            brow_ff <= '0;
            bcol_ff <= '0;
         end
         if (state_ff == S_CELL && cell_v > best_ff) begin
            best_ff <= cell_v;
            brow_ff <= i_ff;
            bcol_ff <= j_ff;
         end
         if (state_ff == S_FIN) begin
            len1_ff <= '0;
            len2_ff <= '0;
            drop_ff <= 1'b0;
         end
      end
   end

   // Sweep and walk-back counters.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_INIT: begin
            i_ff <= ONE;
         end
         S_ROWA: begin
            a_ff <= first_q;
         end
         S_ROWB: begin
            wt_ff   <= cur_wt;
            diag_ff <= '0;
            j_ff    <= ONE;
         end
         S_CELL: begin
            diag_ff <= above;
            j_ff    <= j_ff + ONE;
            if (j_ff >= len2_ff) begin
               i_ff <= i_ff + ONE;
            end
         end
         S_TB0: begin
            s_ff  <= best_ff;
            ti_ff <= brow_ff;
            tj_ff <= bcol_ff;
            n_ff  <= '0;
            k_ff  <= '0;
         end
         S_TBW: begin
            match_ff <= (first_q == second_q);
         end
         S_TBU: begin
            s_ff  <= tb_next;
            n_ff  <= n_ff + ONE;
            ti_ff <= ti_m1;
            tj_ff <= tj_m1;
         end
         S_EMWR: begin
            if (out_free) begin
               k_ff <= k_ff + ONE;
            end
         end
         default: begin
            i_ff <= i_ff;
         end
      endcase
   end

   // Result register: holds one word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (out_load) begin
         rv_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         r_score_ff <= best_ff;
         r_e1_ff    <= POS_W'(brow_ff);
         r_e2_ff    <= POS_W'(bcol_ff);
         r_over_ff  <= drop_ff;
         if (state_ff == S_EMPTY) begin
            r_sym_ff   <= '0;
            r_empty_ff <= 1'b1;
            r_last_ff  <= 1'b1;
         end else begin
            r_sym_ff   <= first_q;
            r_empty_ff <= 1'b0;
            r_last_ff  <= (k_ff == n_ff - ONE);
         end
      end
   end

   assign rsp_ch.valid         = rv_ff;
   assign rsp_ch.best_score    = r_score_ff;
   assign rsp_ch.out_symbol    = r_sym_ff;
   assign rsp_ch.is_empty      = r_empty_ff;
   assign rsp_ch.end_in_first  = r_e1_ff;
   assign rsp_ch.end_in_second = r_e2_ff;
   assign rsp_ch.overflowed    = r_over_ff;
   assign rsp_ch.last_of_run   = r_last_ff;

endmodule
`default_nettype wire

/* hdl/weighted_common_substring_dp.sv */
// Top level of the weighted common substring block.
//
// Usage: weight words (kind 0) load the per-character match weights, then
// characters of the first (kind 1) and second (kind 2) string arrive one
// word each on req_ch. The second-string word with end_of_input set starts
// a run. The user writes the unit weight mode and mismatch penalty on the
// csr_ port only while the block is idle; the block does not enforce this.
// While the back end is idle, loading words are absorbed at one per cycle
// through a two-entry queue. A run sweeps the score grid at one cell per
// cycle, passing through S_ROWA and S_ROWB at the start of each row.
// The walk back then steps through S_TBR, S_TBW and S_TBU per character,
// and each result word on rsp_ch is read in S_EMRD and loaded in S_EMWR.
// A run with no positive cell yields a single empty result word.
// Reset clears the lengths, the weight table and the registers to their
// defaults; no words are lost across a stalled receiver, the back end just
// waits with the next result until the result register is free.
`default_nettype none
module weighted_common_substring_dp import wcs_pkg::*; #(
   parameter int MAX_LEN = 64,
   parameter int WEIGHT_FRAC_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   wcs_req_if.sink                    req_ch,
   wcs_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic       push, full, pop, pop_valid;
   cmd_type    push_cmd, pop_cmd;
   csr_wr_type csr;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   // Front end classifies incoming words.
   wcs_front u_front (
      .req_ch     (req_ch),
      .queue_full (full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Command queue decouples the two sides.
   wcs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd)
   );

   // Back end runs the sweep and emits results.
   wcs_back #(
      .MAX_LEN          (MAX_LEN),
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_pop   (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire
